>>> rtl/fgi_pkg.sv
// Shared types, codes and saturating helpers for the face gradient block.
// No dependencies; imported by the top, the datapath and the controller.
`timescale 1ns / 1ps
`default_nettype none

package fgi_pkg;

  // word format
  localparam int DW = 32;
  localparam int FB = 16;
  localparam logic signed [DW-1:0] MAXV   = 32'sh7fffffff;
  localparam logic signed [DW-1:0] MINV   = 32'sh80000000;
  localparam logic signed [DW-1:0] ONE_W  = 32'sh00010000;
  localparam logic signed [DW-1:0] HALF_W = 32'sh00008000;

  // command codes
  localparam logic [2:0] CMD_DIR   = 3'd0;
  localparam logic [2:0] CMD_R0    = 3'd1;
  localparam logic [2:0] CMD_R1    = 3'd2;
  localparam logic [2:0] CMD_OWNER = 3'd3;
  localparam logic [2:0] CMD_NBR   = 3'd4;

  // boundary condition codes
  localparam logic [1:0] BC_INT = 2'd0;
  localparam logic [1:0] BC_DIR = 2'd1;
  localparam logic [1:0] BC_NEU = 2'd2;
  localparam logic [1:0] BC_ROB = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BC = 2'd1;
  localparam logic [1:0] ST_DZ = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] cell_value;
    logic [1:0]        bc_mode;
  } fgi_in_t;

  typedef struct packed {
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic [1:0]        status;
  } fgi_out_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_ACC, OP_SQRT_GO, OP_SET_DIST, OP_SET_R0, OP_SET_L1,
    OP_DIV_GO, OP_SET_UD, OP_CLR_UD, OP_SET_KSI, OP_HALF_KSI, OP_STORE_OWNER,
    OP_PRED_T, OP_PRED_SET, OP_PRED_OG, OP_SET_Q, OP_PD_ADD, OP_SET_S,
    OP_SET_G, OP_EMIT_OK, OP_EMIT_BC, OP_EMIT_DZ
  } fgi_op_t;

  typedef enum logic [2:0] {
    MS_SQ, MS_KSI_OG, MS_REST_V, MS_PRED_UD, MS_S_UD
  } fgi_msel_t;

  typedef enum logic [1:0] {
    DS_UD, DS_KSI, DS_Q
  } fgi_dsel_t;

  typedef struct packed {
    fgi_op_t   op;
    logic      mul_en;
    fgi_msel_t msel;
    fgi_dsel_t dsel;
    logic [1:0] idx;
  } fgi_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] bc_mode;
    logic       dist_zero;
    logic       den_zero;
    logic       sqrt_done;
    logic       div_done;
  } fgi_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SQ_MUL, S_SQ_ACC, S_SQRT_GO, S_SQRT_WAIT,
    S_UD_CHK, S_UD_GO, S_UD_WAIT, S_KSI_CHK, S_KSI_WAIT,
    S_PRED_M1, S_PRED_M2, S_PRED_SET, S_Q_GO, S_Q_WAIT,
    S_PD_MUL, S_PD_ADD, S_SET_S, S_G_MUL, S_G_SET, S_EMIT
  } fgi_state_t;

  // magnitude of a signed word as unsigned
  function automatic logic [31:0] mag(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  // signed word from a magnitude and sign, saturated
  function automatic logic signed [31:0] sat_mag(input logic [47:0] m, input logic neg);
    if (m > 48'h0000_7fff_ffff) return neg ? MINV : MAXV;
    return neg ? (~m[31:0] + 32'd1) : m[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? MINV : MAXV;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? MINV : MAXV;
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/face_gradient_interpolation.sv
// Face gradient with non-orthogonal correction, Q16.16; one item at a time.
// Direction takes a root, then three divides; offset r0 a root; offset r1 a root, then one divide;
// owner data is only stored; neighbour data one divide. Multiplier, divider and root unit are shared.
// A result strobes out_valid for one cycle, in the cycle after its emit step; no stall.
// Synchronous active-low reset clears all stored geometry and owner data to zero.
`timescale 1ns / 1ps
`default_nettype none

module face_gradient_interpolation
  import fgi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire fgi_in_t in_data,
  output logic         out_valid,
  output fgi_out_t     out_data
);

  fgi_cmd_t  cmd;
  fgi_stat_t stat;

  // sequencer
  fgi_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  // arithmetic and storage
  fgi_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data),
    .out_valid(out_valid)
  );

endmodule

`default_nettype wire

>>> rtl/fgi_div.sv
// Iterative restoring divider, one quotient bit per cycle, 48 quotient bits.
// Uses nothing from the package.
`timescale 1ns / 1ps
`default_nettype none

module fgi_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [47:0] num,
  input  wire logic [32:0] den,
  output logic             done,
  output logic [47:0]      quo
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [33:0] rem_r;
  logic [47:0] quo_r;
  logic [32:0] den_r;
  logic [33:0] rem_s, rem_nxt;
  logic        ge;

  // one restoring step
  always_comb begin
    rem_s   = {rem_r[32:0], quo_r[47]};
    ge      = rem_s >= {1'b0, den_r};
    rem_nxt = ge ? (rem_s - {1'b0, den_r}) : rem_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd47;
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[46:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/fgi_sqrt.sv
// Iterative integer square root, one root bit per cycle, 32 root bits.
// Uses nothing from the package.
`timescale 1ns / 1ps
`default_nettype none

module fgi_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [63:0] rad,
  output logic             done,
  output logic [31:0]      root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [35:0] rem_s, trial, rem_d;
  logic        ge;

  // one digit step
  always_comb begin
    rem_s = {rem_r, x_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    ge    = rem_s >= trial;
    rem_d = ge ? (rem_s - trial) : rem_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        x_r    <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r    <= {x_r[61:0], 2'b00};
        rem_r  <= rem_d[33:0];
        root_r <= {root_r[30:0], ge};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

>>> rtl/fgi_datapath.sv
// Datapath: stored geometry and owner data, shared multiplier, divider and root unit.
// Depends on fgi_pkg, fgi_div and fgi_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module fgi_datapath
  import fgi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire fgi_in_t  in_data,
  input  wire fgi_cmd_t cmd,
  output fgi_stat_t     stat,
  output fgi_out_t      out_data,
  output logic          out_valid
);

  fgi_in_t            in_r;
  logic signed [31:0] ud_r [3];
  logic signed [31:0] og_r [3];
  logic signed [31:0] pred_r [3];
  logic signed [31:0] g_r [3];
  logic signed [31:0] dist_r, r0len_r, len1_r, ksi_r, ov_r;
  logic signed [31:0] t_r, q_r, pd_r, s_r;
  logic [63:0]        acc_r, prod_r;
  logic               pneg_r, dneg_r;
  fgi_out_t           out_r;
  logic               out_valid_r;

  logic signed [31:0] v_sel, mul_a, mul_b, rest, diff, mulq_w, divq_w, lenw;
  logic [47:0]        div_num, div_quo;
  logic [32:0]        div_den;
  logic               div_neg, div_done, sqrt_done;
  logic [31:0]        root;

  fgi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.op == OP_DIV_GO),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  fgi_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.op == OP_SQRT_GO),
    .rad  (acc_r),
    .done (sqrt_done),
    .root (root)
  );

  // operand selection
  always_comb begin
    case (cmd.idx)
      2'd1:    v_sel = in_r.vec_y;
      2'd2:    v_sel = in_r.vec_z;
      default: v_sel = in_r.vec_x;
    endcase
    rest = ONE_W - ksi_r;
    diff = sat_sub(in_r.cell_value, ov_r);
    case (cmd.msel)
      MS_SQ:      begin mul_a = v_sel;           mul_b = v_sel;           end
      MS_KSI_OG:  begin mul_a = ksi_r;           mul_b = og_r[cmd.idx];   end
      MS_REST_V:  begin mul_a = rest;            mul_b = v_sel;           end
      MS_PRED_UD: begin mul_a = pred_r[cmd.idx]; mul_b = ud_r[cmd.idx];   end
      MS_S_UD:    begin mul_a = s_r;             mul_b = ud_r[cmd.idx];   end
      default:    begin mul_a = '0;              mul_b = '0;              end
    endcase
    case (cmd.dsel)
      DS_UD: begin
        div_num = {mag(v_sel), 16'h0000};
        div_den = {1'b0, dist_r};
        div_neg = v_sel[31];
      end
      DS_KSI: begin
        div_num = {len1_r, 16'h0000};
        div_den = {1'b0, r0len_r} + {1'b0, len1_r};
        div_neg = 1'b0;
      end
      DS_Q: begin
        div_num = {mag(diff), 16'h0000};
        div_den = {1'b0, dist_r};
        div_neg = diff[31];
      end
      default: begin
        div_num = '0;
        div_den = '0;
        div_neg = 1'b0;
      end
    endcase
  end

  // scaled product, quotient and clamped length
  assign mulq_w = sat_mag(prod_r[63:FB], pneg_r);
  assign divq_w = sat_mag(div_quo, dneg_r);
  assign lenw   = root[31] ? MAXV : root;

  // multiplier, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mag(mul_a) * mag(mul_b);
      pneg_r <= mul_a[31] ^ mul_b[31];
    end
  end

  // stored geometry and owner data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ud_r[i] <= '0;
        og_r[i] <= '0;
      end
      dist_r  <= '0;
      r0len_r <= '0;
      ksi_r   <= '0;
      ov_r    <= '0;
    end else begin
      case (cmd.op)
        OP_SET_DIST: dist_r  <= lenw;
        OP_SET_R0:   r0len_r <= lenw;
        OP_SET_UD:   ud_r[cmd.idx] <= divq_w;
        OP_CLR_UD: begin
          for (int i = 0; i < 3; i++) ud_r[i] <= '0;
        end
        OP_SET_KSI:  ksi_r <= divq_w;
        OP_HALF_KSI: ksi_r <= HALF_W;
        OP_STORE_OWNER: begin
          og_r[0] <= in_r.vec_x;
          og_r[1] <= in_r.vec_y;
          og_r[2] <= in_r.vec_z;
          ov_r    <= in_r.cell_value;
        end
        default: ;
      endcase
    end
  end

  // working registers of one item
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:     in_r   <= in_data;
      OP_ACC:      acc_r  <= (cmd.idx == 2'd0) ? prod_r : (acc_r + prod_r);
      OP_SET_L1:   len1_r <= lenw;
      OP_DIV_GO:   dneg_r <= div_neg;
      OP_PRED_T:   t_r    <= mulq_w;
      OP_PRED_SET: pred_r[cmd.idx] <= sat_add(t_r, mulq_w);
      OP_PRED_OG: begin
        for (int i = 0; i < 3; i++) pred_r[i] <= og_r[i];
      end
      OP_SET_Q:    q_r  <= divq_w;
      OP_PD_ADD:   pd_r <= sat_add((cmd.idx == 2'd0) ? 32'sd0 : pd_r, mulq_w);
      OP_SET_S:    s_r  <= sat_sub(q_r, pd_r);
      OP_SET_G:    g_r[cmd.idx] <= sat_add(pred_r[cmd.idx], mulq_w);
      default: ;
    endcase
  end

  // result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT_OK) || (cmd.op == OP_EMIT_BC) ||
                     (cmd.op == OP_EMIT_DZ);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_EMIT_OK: out_r <= '{grad_x: g_r[0], grad_y: g_r[1], grad_z: g_r[2], status: ST_OK};
      OP_EMIT_BC: out_r <= '{grad_x: '0, grad_y: '0, grad_z: '0, status: ST_BC};
      OP_EMIT_DZ: out_r <= '{grad_x: '0, grad_y: '0, grad_z: '0, status: ST_DZ};
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    stat.command   = in_r.command;
    stat.bc_mode   = in_r.bc_mode;
    stat.dist_zero = (dist_r == 32'sd0);
    stat.den_zero  = (r0len_r == 32'sd0) && (len1_r == 32'sd0);
    stat.sqrt_done = sqrt_done;
    stat.div_done  = div_done;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/fgi_ctrl.sv
// Controller state machine: sequences datapath operations for each command.
// Depends on fgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fgi_ctrl
  import fgi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire fgi_stat_t stat,
  output fgi_cmd_t       cmd,
  output logic           busy
);

  fgi_state_t state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        idx_nxt   = 2'd0;
        state_nxt = S_IDLE;
        if (stat.command == CMD_DIR || stat.command == CMD_R0 ||
            stat.command == CMD_R1) begin
          state_nxt = S_SQ_MUL;
        end else if (stat.command == CMD_NBR && !stat.dist_zero) begin
          if (stat.bc_mode == BC_INT)      state_nxt = S_PRED_M1;
          else if (stat.bc_mode == BC_DIR) state_nxt = S_Q_GO;
        end
      end
      S_SQ_MUL: state_nxt = S_SQ_ACC;
      S_SQ_ACC: begin
        if (idx_r == 2'd2) state_nxt = S_SQRT_GO;
        else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQRT_GO: state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          if (stat.command == CMD_DIR)     state_nxt = S_UD_CHK;
          else if (stat.command == CMD_R0) state_nxt = S_IDLE;
          else                             state_nxt = S_KSI_CHK;
        end
      end
      S_UD_CHK: begin
        idx_nxt   = 2'd0;
        state_nxt = stat.dist_zero ? S_IDLE : S_UD_GO;
      end
      S_UD_GO: state_nxt = S_UD_WAIT;
      S_UD_WAIT: begin
        if (stat.div_done) begin
          if (idx_r == 2'd2) state_nxt = S_IDLE;
          else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_UD_GO;
          end
        end
      end
      S_KSI_CHK:  state_nxt = stat.den_zero ? S_IDLE : S_KSI_WAIT;
      S_KSI_WAIT: if (stat.div_done) state_nxt = S_IDLE;
      S_PRED_M1:  state_nxt = S_PRED_M2;
      S_PRED_M2:  state_nxt = S_PRED_SET;
      S_PRED_SET: begin
        if (idx_r == 2'd2) state_nxt = S_Q_GO;
        else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_PRED_M1;
        end
      end
      S_Q_GO: state_nxt = S_Q_WAIT;
      S_Q_WAIT: begin
        if (stat.div_done) begin
          idx_nxt   = 2'd0;
          state_nxt = S_PD_MUL;
        end
      end
      S_PD_MUL: state_nxt = S_PD_ADD;
      S_PD_ADD: begin
        if (idx_r == 2'd2) state_nxt = S_SET_S;
        else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_PD_MUL;
        end
      end
      S_SET_S: begin
        idx_nxt   = 2'd0;
        state_nxt = S_G_MUL;
      end
      S_G_MUL: state_nxt = S_G_SET;
      S_G_SET: begin
        if (idx_r == 2'd2) state_nxt = S_EMIT;
        else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_G_MUL;
        end
      end
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op     = OP_NOP;
    cmd.mul_en = 1'b0;
    cmd.msel   = MS_SQ;
    cmd.dsel   = DS_UD;
    cmd.idx    = idx_r;
    case (state_r)
      S_IDLE: if (start) cmd.op = OP_LOAD;
      S_DECODE: begin
        if (stat.command == CMD_OWNER) cmd.op = OP_STORE_OWNER;
        else if (stat.command == CMD_NBR) begin
          if (stat.bc_mode == BC_ROB)      cmd.op = OP_EMIT_BC;
          else if (stat.bc_mode == BC_NEU) cmd.op = OP_NOP;
          else if (stat.dist_zero)         cmd.op = OP_EMIT_DZ;
          else if (stat.bc_mode == BC_DIR) cmd.op = OP_PRED_OG;
        end
      end
      S_SQ_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MS_SQ;
      end
      S_SQ_ACC:  cmd.op = OP_ACC;
      S_SQRT_GO: cmd.op = OP_SQRT_GO;
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          if (stat.command == CMD_DIR)     cmd.op = OP_SET_DIST;
          else if (stat.command == CMD_R0) cmd.op = OP_SET_R0;
          else                             cmd.op = OP_SET_L1;
        end
      end
      S_UD_CHK: if (stat.dist_zero) cmd.op = OP_CLR_UD;
      S_UD_GO: begin
        cmd.op   = OP_DIV_GO;
        cmd.dsel = DS_UD;
      end
      S_UD_WAIT: if (stat.div_done) cmd.op = OP_SET_UD;
      S_KSI_CHK: begin
        cmd.dsel = DS_KSI;
        cmd.op   = stat.den_zero ? OP_HALF_KSI : OP_DIV_GO;
      end
      S_KSI_WAIT: if (stat.div_done) cmd.op = OP_SET_KSI;
      S_PRED_M1: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MS_KSI_OG;
      end
      S_PRED_M2: begin
        cmd.op     = OP_PRED_T;
        cmd.mul_en = 1'b1;
        cmd.msel   = MS_REST_V;
      end
      S_PRED_SET: cmd.op = OP_PRED_SET;
      S_Q_GO: begin
        cmd.op   = OP_DIV_GO;
        cmd.dsel = DS_Q;
      end
      S_Q_WAIT: if (stat.div_done) cmd.op = OP_SET_Q;
      S_PD_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MS_PRED_UD;
      end
      S_PD_ADD: cmd.op = OP_PD_ADD;
      S_SET_S:  cmd.op = OP_SET_S;
      S_G_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.msel   = MS_S_UD;
      end
      S_G_SET: cmd.op = OP_SET_G;
      S_EMIT:  cmd.op = OP_EMIT_OK;
      default: cmd.op = OP_NOP;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire
